### rtl/core/target_follow_drive_controller_core_assert.svh
// Assertion macros for the target follow drive controller.
// Users must have signals named clock and reset in scope.
`ifndef TARGET_FOLLOW_DRIVE_CONTROLLER_CORE_ASSERT_SVH
`define TARGET_FOLLOW_DRIVE_CONTROLLER_CORE_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define TFD_ASSERT_SAME(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("assertion failed: a implies b");

// Condition a implies condition b in the following cycle.
`define TFD_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("assertion failed: a implies b next cycle");

`endif

### rtl/core/tfd_pkg.sv
// Shared types, codes and helpers for the target follow drive controller.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package tfd_pkg;

   typedef enum logic [2:0] {
      MODE_AHEAD      = 3'd0,
      MODE_RIGHT      = 3'd1,
      MODE_LOST_LEFT  = 3'd2,
      MODE_LOST_RIGHT = 3'd3,
      MODE_BUMPED     = 3'd4
   } mode_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_LEFT_NEUTRAL    = 3'd0;
   localparam logic [2:0] CSR_RIGHT_NEUTRAL   = 3'd1;
   localparam logic [2:0] CSR_LEFT_FWD_OFS    = 3'd2;
   localparam logic [2:0] CSR_RIGHT_FWD_OFS   = 3'd3;
   localparam logic [2:0] CSR_LEFT_REV_BASE   = 3'd4;
   localparam logic [2:0] CSR_RIGHT_REV_BASE  = 3'd5;
   localparam logic [2:0] CSR_FRONT_NEAR      = 3'd6;
   localparam logic [2:0] CSR_RIGHT_NEAR      = 3'd7;

   localparam int CSR_DATA_W = 16;
   localparam int CALC_W     = 19;

   localparam logic signed [10:0]       FWD_CENTER = 11'sd28;
   localparam logic signed [CALC_W-1:0] FWD_GAIN   = 19'sd60;
   localparam logic signed [CALC_W-1:0] CW_STEP    = 19'sd600;
   localparam logic signed [CALC_W-1:0] CCW_STEP   = 19'sd250;
   localparam logic signed [16:0]       TURN_LIMIT = 17'sd1;

   typedef struct packed {
      logic [15:0] left_neutral;
      logic [15:0] right_neutral;
      logic [11:0] left_forward_offset;
      logic [11:0] right_forward_offset;
      logic [11:0] left_reverse_base;
      logic [11:0] right_reverse_base;
      logic [8:0]  front_near_limit;
      logic [8:0]  right_near_limit;
   } cfg_type;

   typedef struct packed {
      logic               bump_left;
      logic               bump_right;
      logic signed [9:0]  front_distance;
      logic signed [9:0]  right_distance;
      logic signed [15:0] heading_deg;
   } req_type;

   typedef struct packed {
      logic               phase;
      mode_type           mode;
      logic signed [15:0] saved_heading;
   } state_type;

   typedef struct packed {
      mode_type    mode;
      logic        drive_phase;
      logic        pwm_update;
      logic [15:0] left_pwm;
      logic [15:0] right_pwm;
   } rsp_type;

   // Clamp a signed intermediate to the 16-bit compare range.
   function automatic logic [15:0] sat16(input logic signed [CALC_W-1:0] v);
      logic [15:0] r;
      if (v < 0) begin
         r = 16'd0;
      end else if (v > $signed({{(CALC_W-16){1'b0}}, 16'hFFFF})) begin
         r = 16'hFFFF;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/target_follow_drive_controller_core.sv
// Top level of the target follow drive controller: input register, pass logic,
// loop state and result register. Depends on tfd_pkg, tfd_csr and tfd_pass.
`timescale 1ns / 1ps

// Each request beat is one control-loop pass and gives exactly one response
// beat, registered first in the input register and then in the result register.
// A new beat is taken every cycle while the response side is not stalled: the
// beat in the input register is worked through the pass logic into the result
// register, and the loop state (phase, mode, saved heading) is updated on that
// same edge, so one pass per cycle is sustained. Configuration writes take
// effect on the next edge and should be made only while no beat is in flight.
module target_follow_drive_controller_core
   import tfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_bump_left,
   input  logic                  req_bump_right,
   input  logic signed [9:0]     req_front_distance,
   input  logic signed [9:0]     req_right_distance,
   input  logic signed [15:0]    req_heading_deg,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_mode,
   output logic                  rsp_drive_phase,
   output logic                  rsp_pwm_update,
   output logic [15:0]           rsp_left_pwm,
   output logic [15:0]           rsp_right_pwm,
   input  logic                  csr_write_en,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "target_follow_drive_controller_core_assert.svh"

   cfg_type   cfg;
   req_type   req_in;
   req_type   s1_req_ff;
   logic      s1_valid_ff;
   logic      s1_valid_in;
   logic      s1_adv;
   state_type state_ff;
   state_type state_in;
   rsp_type   pass_rsp;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_accept;
   logic      rsp_write;
   logic      rsp_ahead;
   logic      rsp_bumped;

   tfd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   tfd_pass u_pass (
      .cfg (cfg),
      .cur (state_ff),
      .req (s1_req_ff),
      .nxt (state_in),
      .rsp (pass_rsp)
   );

   always_comb begin
      req_in.bump_left      = req_bump_left;
      req_in.bump_right     = req_bump_right;
      req_in.front_distance = req_front_distance;
      req_in.right_distance = req_right_distance;
      req_in.heading_deg    = req_heading_deg;
   end

   // The input beat moves on whenever the result register is free or drains.
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         state_ff.phase         <= 1'b0;
         state_ff.mode          <= MODE_AHEAD;
         state_ff.saved_heading <= 16'sd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_in;
      end
      if (s1_adv) begin
         rsp_ff <= pass_rsp;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mode        = rsp_ff.mode;
   assign rsp_drive_phase = rsp_ff.drive_phase;
   assign rsp_pwm_update  = rsp_ff.pwm_update;
   assign rsp_left_pwm    = rsp_ff.left_pwm;
   assign rsp_right_pwm   = rsp_ff.right_pwm;

   assign rsp_write  = rsp_valid_ff && rsp_ff.pwm_update;
   assign rsp_ahead  = (rsp_ff.mode == MODE_AHEAD);
   assign rsp_bumped = (rsp_ff.mode == MODE_BUMPED);

   // A forward-drive write always hands the loop back to the verify phase.
   `TFD_ASSERT_SAME(a_ahead_write_ends_drive, rsp_write && rsp_ahead, !rsp_ff.drive_phase)
   // A write that ends in verify comes only from forward drive or reverse.
   `TFD_ASSERT_SAME(a_write_to_verify_mode, rsp_write && !rsp_ff.drive_phase, rsp_ahead || rsp_bumped)
   // A beat held in the input register is not lost while the output stalls.
   `TFD_ASSERT_NEXT(a_s1_held_on_stall, s1_valid_ff && !s1_adv, s1_valid_ff)

endmodule

### rtl/core/tfd_csr.sv
// Configuration registers of the target follow drive controller.
// Depends on tfd_pkg for the register indexes and the cfg_type struct.
`timescale 1ns / 1ps

module tfd_csr
   import tfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_LEFT_NEUTRAL:   cfg_in.left_neutral         = csr_wdata[15:0];
            CSR_RIGHT_NEUTRAL:  cfg_in.right_neutral        = csr_wdata[15:0];
            CSR_LEFT_FWD_OFS:   cfg_in.left_forward_offset  = csr_wdata[11:0];
            CSR_RIGHT_FWD_OFS:  cfg_in.right_forward_offset = csr_wdata[11:0];
            CSR_LEFT_REV_BASE:  cfg_in.left_reverse_base    = csr_wdata[11:0];
            CSR_RIGHT_REV_BASE: cfg_in.right_reverse_base   = csr_wdata[11:0];
            CSR_FRONT_NEAR:     cfg_in.front_near_limit     = csr_wdata[8:0];
            CSR_RIGHT_NEAR:     cfg_in.right_near_limit     = csr_wdata[8:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_neutral         <= 16'd4700;
         cfg_ff.right_neutral        <= 16'd4800;
         cfg_ff.left_forward_offset  <= 12'd600;
         cfg_ff.right_forward_offset <= 12'd250;
         cfg_ff.left_reverse_base    <= 12'd300;
         cfg_ff.right_reverse_base   <= 12'd600;
         cfg_ff.front_near_limit     <= 9'd40;
         cfg_ff.right_near_limit     <= 9'd43;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/tfd_pass.sv
// One control-loop pass: mode decision on verify, PWM compares on drive.
// Purely combinational; depends on tfd_pkg for types and constants.
`timescale 1ns / 1ps

module tfd_pass
   import tfd_pkg::*;
(
   input  cfg_type   cfg,
   input  state_type cur,
   input  req_type   req,
   output state_type nxt,
   output rsp_type   rsp
);

   logic                     front_near;
   logic                     right_near;
   logic signed [16:0]       head_diff;
   logic                     turned;
   logic signed [10:0]       front_ofs;
   logic signed [CALC_W-1:0] term;
   logic signed [CALC_W-1:0] ln;
   logic signed [CALC_W-1:0] rn;
   logic [13:0]              lrb3;
   logic [13:0]              rrb3;
   logic signed [CALC_W-1:0] rev_right;
   logic signed [CALC_W-1:0] lp;
   logic signed [CALC_W-1:0] rp;
   logic                     upd;

   assign front_near = $signed({req.front_distance[9], req.front_distance})
                       < $signed({2'b00, cfg.front_near_limit});
   assign right_near = $signed({req.right_distance[9], req.right_distance})
                       < $signed({2'b00, cfg.right_near_limit});

   assign head_diff = $signed({cur.saved_heading[15], cur.saved_heading})
                      - $signed({req.heading_deg[15], req.heading_deg});
   assign turned    = (head_diff > TURN_LIMIT) || (head_diff < -TURN_LIMIT);

   assign front_ofs = $signed({req.front_distance[9], req.front_distance}) - FWD_CENTER;
   assign term      = $signed({{(CALC_W-11){front_ofs[10]}}, front_ofs}) * FWD_GAIN;

   assign ln = $signed({{(CALC_W-16){1'b0}}, cfg.left_neutral});
   assign rn = $signed({{(CALC_W-16){1'b0}}, cfg.right_neutral});

   // Three times the reverse base; halving it afterward truncates the 1.5 factor.
   assign lrb3 = {2'b00, cfg.left_reverse_base} + {1'b0, cfg.left_reverse_base, 1'b0};
   assign rrb3 = {2'b00, cfg.right_reverse_base} + {1'b0, cfg.right_reverse_base, 1'b0};
   assign rev_right = (rn <<< 1) - $signed({{(CALC_W-14){1'b0}}, rrb3});

   always_comb begin
      nxt = cur;
      upd = 1'b0;
      lp  = '0;
      rp  = '0;
      if (!cur.phase) begin
         if (req.bump_left || req.bump_right) begin
            nxt.mode = MODE_BUMPED;
         end else begin
            if (front_near) begin
               nxt.mode = MODE_AHEAD;
            end else if (right_near) begin
               nxt.mode = MODE_RIGHT;
            end else if (cur.mode == MODE_AHEAD) begin
               nxt.mode = MODE_LOST_LEFT;
            end else if (cur.mode == MODE_RIGHT) begin
               nxt.mode = MODE_LOST_RIGHT;
            end
            nxt.saved_heading = req.heading_deg;
            nxt.phase         = 1'b1;
         end
      end else begin
         case (cur.mode)
            MODE_AHEAD: begin
               lp = ln - $signed({{(CALC_W-12){1'b0}}, cfg.left_forward_offset}) - term;
               rp = rn + $signed({{(CALC_W-12){1'b0}}, cfg.right_forward_offset}) + term;
               upd = 1'b1;
               nxt.phase = 1'b0;
            end
            MODE_RIGHT, MODE_LOST_RIGHT: begin
               if (turned) begin
                  nxt.phase = 1'b0;
               end else begin
                  lp  = ln - CW_STEP;
                  rp  = rn - CW_STEP;
                  upd = 1'b1;
               end
            end
            MODE_LOST_LEFT: begin
               if (turned) begin
                  nxt.phase = 1'b0;
               end else begin
                  lp  = ln + CCW_STEP;
                  rp  = rn + CCW_STEP;
                  upd = 1'b1;
               end
            end
            MODE_BUMPED: begin
               lp = ln + $signed({{(CALC_W-13){1'b0}}, lrb3[13:1]});
               rp = (rev_right <= 0) ? '0 : (rev_right >>> 1);
               upd = 1'b1;
               nxt.phase = 1'b0;
            end
            default: begin
               upd = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp.mode        = nxt.mode;
      rsp.drive_phase = nxt.phase;
      rsp.pwm_update  = upd;
      rsp.left_pwm    = upd ? sat16(lp) : 16'd0;
      rsp.right_pwm   = upd ? sat16(rp) : 16'd0;
   end

endmodule
